// ----- rtl/core/keyword_hit_counter_unit_macros.svh -----
// assertion macros shared by the keyword hit counter checker
`ifndef KEYWORD_HIT_COUNTER_UNIT_MACROS_SVH
`define KEYWORD_HIT_COUNTER_UNIT_MACROS_SVH

// implication checked in the same cycle
`define KWC_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("keyword hit counter check failed");

// implication checked in the next cycle
`define KWC_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("keyword hit counter check failed");

`endif

// ----- rtl/core/kwc_pkg.sv -----
// shared types, constants and character helpers for the keyword hit counter
package kwc_pkg;

    localparam int NUM_KEYS_DEF  = 32;
    localparam int MAX_CHARS_DEF = 10;
    localparam int CODE_W        = 6;
    localparam int OP_W          = 3;
    localparam int SYM_W         = 8;
    localparam int LINE_W        = 16;
    localparam int COUNT_W       = 8;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR    = 3'd0,
        OP_KEY_CHAR = 3'd1,
        OP_KEY_END  = 3'd2,
        OP_TEXT     = 3'd3,
        OP_LINE_END = 3'd4
    } op_t;

    // control of one character packer
    typedef struct packed {
        logic clr;
        logic push;
        logic mark;
    } build_ctl_t;

    // one line result
    typedef struct packed {
        logic [LINE_W-1:0]  line_number;
        logic [COUNT_W-1:0] hit_count;
        logic [COUNT_W-1:0] best_count;
        logic [LINE_W-1:0]  best_line;
        logic               keys_dropped;
    } result_t;

    // digits map to 1..10, lower case letters to 11..36, anything else to 0
    function automatic logic [CODE_W-1:0] char_code(input logic [SYM_W-1:0] c);
        logic [CODE_W-1:0] code;
        code = '0;
        if (c >= SYM_W'("0") && c <= SYM_W'("9")) begin
            code = CODE_W'(c - SYM_W'("0")) + CODE_W'(1);
        end else if (c >= SYM_W'("a") && c <= SYM_W'("z")) begin
            code = CODE_W'(c - SYM_W'("a")) + CODE_W'(11);
        end
        return code;
    endfunction

    function automatic logic [SYM_W-1:0] fold_upper(input logic [SYM_W-1:0] c);
        logic [SYM_W-1:0] r;
        r = c;
        if (c >= SYM_W'("A") && c <= SYM_W'("Z")) begin
            r = c - SYM_W'("A") + SYM_W'("a");
        end
        return r;
    endfunction

endpackage

// ----- rtl/core/kwc_word_builder.sv -----
// packs character codes into a word, with length tracking and a flag for overflow or a marked bad character
module kwc_word_builder #(
    parameter int MAX_WORD_CHARS = kwc_pkg::MAX_CHARS_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  kwc_pkg::build_ctl_t                       ctl,
    input  logic [kwc_pkg::CODE_W-1:0]                code,
    output logic [kwc_pkg::CODE_W*MAX_WORD_CHARS-1:0] word,
    output logic                                      empty,
    output logic                                      flag
);
    import kwc_pkg::*;

    localparam int WORD_W = CODE_W * MAX_WORD_CHARS;
    localparam int LEN_W  = $clog2(MAX_WORD_CHARS + 1);

    logic [WORD_W-1:0] word_reg, word_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              flag_reg, flag_next;

    always_comb begin
        word_next = word_reg;
        len_next  = len_reg;
        flag_next = flag_reg;
        if (ctl.clr) begin
            word_next = '0;
            len_next  = '0;
            flag_next = 1'b0;
        end else if (ctl.mark) begin
            flag_next = 1'b1;
        end else if (ctl.push) begin
            if (len_reg >= LEN_W'(MAX_WORD_CHARS)) begin
                flag_next = 1'b1;
            end else begin
                for (int i = 0; i < MAX_WORD_CHARS; i++) begin
                    if (len_reg == LEN_W'(i)) begin
                        word_next[i*CODE_W +: CODE_W] = code;
                    end
                end
                len_next = len_reg + LEN_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg <= '0;
            len_reg  <= '0;
            flag_reg <= 1'b0;
        end else begin
            word_reg <= word_next;
            len_reg  <= len_next;
            flag_reg <= flag_next;
        end
    end

    assign word  = word_reg;
    assign empty = (len_reg == '0);
    assign flag  = flag_reg;

endmodule

// ----- rtl/core/kwc_key_cell.sv -----
// one keyword slot: holds a key, passes it on when the chain shifts, compares
module kwc_key_cell #(
    parameter int WORD_W = kwc_pkg::CODE_W * kwc_pkg::MAX_CHARS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clr,
    input  logic              shift,
    input  logic [WORD_W-1:0] key_in,
    input  logic              valid_in,
    input  logic [WORD_W-1:0] word,
    output logic [WORD_W-1:0] key_out,
    output logic              valid_out,
    output logic              hit
);
    logic [WORD_W-1:0] key_reg;
    logic              valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (clr) begin
            valid_reg <= 1'b0;
        end else if (shift) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (shift) begin
            key_reg <= key_in;
        end
    end

    assign key_out   = key_reg;
    assign valid_out = valid_reg;
    assign hit       = valid_reg && (key_reg == word);

endmodule

// ----- rtl/core/kwc_key_chain.sv -----
// row of keyword cells; a commit shifts the row by one, compare is parallel
module kwc_key_chain #(
    parameter int NUM_KEYS = kwc_pkg::NUM_KEYS_DEF,
    parameter int WORD_W   = kwc_pkg::CODE_W * kwc_pkg::MAX_CHARS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              clr,
    input  logic              shift,
    input  logic [WORD_W-1:0] key_in,
    input  logic [WORD_W-1:0] word,
    output logic              full,
    output logic              hit
);
    logic [WORD_W-1:0] key_link   [NUM_KEYS+1];
    logic              valid_link [NUM_KEYS+1];
    logic [NUM_KEYS-1:0] hit_vec;

    assign key_link[0]   = key_in;
    assign valid_link[0] = 1'b1;

    for (genvar g = 0; g < NUM_KEYS; g++) begin : g_cell
        kwc_key_cell #(
            .WORD_W (WORD_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .clr       (clr),
            .shift     (shift),
            .key_in    (key_link[g]),
            .valid_in  (valid_link[g]),
            .word      (word),
            .key_out   (key_link[g+1]),
            .valid_out (valid_link[g+1]),
            .hit       (hit_vec[g])
        );
    end

    // the row fills from the head, so the tail cell is valid only when all are
    assign full = valid_link[NUM_KEYS];
    assign hit  = |hit_vec;

endmodule

// ----- rtl/core/keyword_hit_counter_unit.sv -----
// top level of the keyword hit counter: decode, word packing, line tally
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------------
//  s_       | in        | s_valid / s_ready  | s_operation, s_symbol
//  m_       | out       | m_valid / m_ready  | m_line_number, m_hit_count, m_best_count,
//           |           |                    | m_best_line, m_keys_dropped
//
//  one request per cycle while s_ready is high; every request completes in the cycle it is taken
//  a line end's result is registered into the output register, or into the skid entry if m_ is stalled
//  the word compare against all key cells and the hit increment happen in the same cycle
//  a two-entry output buffer lets requests flow while one result waits;
//  s_ready drops only when both entries are held
//  aresetn is synchronous, active low, and empties the key row and all counters
module keyword_hit_counter_unit #(
    parameter int NUM_KEYS       = kwc_pkg::NUM_KEYS_DEF,
    parameter int MAX_WORD_CHARS = kwc_pkg::MAX_CHARS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [kwc_pkg::OP_W-1:0]     s_operation,
    input  logic [kwc_pkg::SYM_W-1:0]    s_symbol,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [kwc_pkg::LINE_W-1:0]   m_line_number,
    output logic [kwc_pkg::COUNT_W-1:0]  m_hit_count,
    output logic [kwc_pkg::COUNT_W-1:0]  m_best_count,
    output logic [kwc_pkg::LINE_W-1:0]   m_best_line,
    output logic                         m_keys_dropped
);
    import kwc_pkg::*;

    localparam int WORD_W = CODE_W * MAX_WORD_CHARS;

    // request decode
    logic              s_fire;
    logic              is_clear, is_key_char, is_key_end, is_text, is_line_end;
    logic [CODE_W-1:0] key_code, text_code;

    assign s_fire      = s_valid && s_ready;
    assign is_clear    = s_fire && (s_operation == OP_CLEAR);
    assign is_key_char = s_fire && (s_operation == OP_KEY_CHAR);
    assign is_key_end  = s_fire && (s_operation == OP_KEY_END);
    assign is_text     = s_fire && (s_operation == OP_TEXT);
    assign is_line_end = s_fire && (s_operation == OP_LINE_END);

    // keywords are taken as is, text is case folded first
    assign key_code  = char_code(s_symbol);
    assign text_code = char_code(fold_upper(s_symbol));

    // keyword being loaded
    build_ctl_t        key_ctl;
    logic [WORD_W-1:0] key_word;
    logic              key_empty, key_bad;

    assign key_ctl.clr  = is_clear || is_key_end;
    assign key_ctl.push = is_key_char && (key_code != '0);
    assign key_ctl.mark = is_key_char && (key_code == '0);

    kwc_word_builder #(
        .MAX_WORD_CHARS (MAX_WORD_CHARS)
    ) u_key_builder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (key_ctl),
        .code    (key_code),
        .word    (key_word),
        .empty   (key_empty),
        .flag    (key_bad)
    );

    // text word being built; a separator or line end finishes it
    build_ctl_t        text_ctl;
    logic [WORD_W-1:0] text_word;
    logic              text_empty, text_long;
    logic              finish;

    assign finish        = (is_text && (text_code == '0)) || is_line_end;
    assign text_ctl.clr  = is_clear || finish;
    assign text_ctl.push = is_text && (text_code != '0);
    assign text_ctl.mark = 1'b0;

    kwc_word_builder #(
        .MAX_WORD_CHARS (MAX_WORD_CHARS)
    ) u_text_builder (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (text_ctl),
        .code    (text_code),
        .word    (text_word),
        .empty   (text_empty),
        .flag    (text_long)
    );

    // key row: a good, non-empty keyword enters at the head unless the row is full
    logic commit, row_full, row_hit;

    assign commit = is_key_end && !key_bad && !key_empty;

    kwc_key_chain #(
        .NUM_KEYS (NUM_KEYS),
        .WORD_W   (WORD_W)
    ) u_key_chain (
        .aclk    (aclk),
        .aresetn (aresetn),
        .clr     (is_clear),
        .shift   (commit && !row_full),
        .key_in  (key_word),
        .word    (text_word),
        .full    (row_full),
        .hit     (row_hit)
    );

    // line tally
    logic [COUNT_W-1:0] line_hits_reg, line_hits_next, hits_after;
    logic [LINE_W-1:0]  line_index_reg, line_index_next;
    logic [COUNT_W-1:0] top_count_reg, top_count_next;
    logic [LINE_W-1:0]  top_line_reg, top_line_next;
    logic               drop_flag_reg, drop_flag_next;
    logic               word_hit;
    result_t            res;

    // only a finished word of legal length counts
    assign word_hit = finish && !text_empty && !text_long && row_hit;

    always_comb begin
        hits_after = line_hits_reg;
        if (word_hit && (line_hits_reg != {COUNT_W{1'b1}})) begin
            hits_after = line_hits_reg + COUNT_W'(1);
        end
    end

    always_comb begin
        line_hits_next  = line_hits_reg;
        line_index_next = line_index_reg;
        top_count_next  = top_count_reg;
        top_line_next   = top_line_reg;
        drop_flag_next  = drop_flag_reg;
        if (is_clear) begin
            line_hits_next  = '0;
            line_index_next = '0;
            top_count_next  = '0;
            top_line_next   = '0;
            drop_flag_next  = 1'b0;
        end else if (is_line_end) begin
            line_hits_next = '0;
            // strict compare keeps the earliest line on a tie
            if (hits_after > top_count_reg) begin
                top_count_next = hits_after;
                top_line_next  = line_index_reg;
            end
            if (line_index_reg != {LINE_W{1'b1}}) begin
                line_index_next = line_index_reg + LINE_W'(1);
            end
        end else begin
            line_hits_next = hits_after;
            if (commit && row_full) begin
                drop_flag_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_hits_reg  <= '0;
            line_index_reg <= '0;
            top_count_reg  <= '0;
            top_line_reg   <= '0;
            drop_flag_reg  <= 1'b0;
        end else begin
            line_hits_reg  <= line_hits_next;
            line_index_reg <= line_index_next;
            top_count_reg  <= top_count_next;
            top_line_reg   <= top_line_next;
            drop_flag_reg  <= drop_flag_next;
        end
    end

    // result of the line that ends in this cycle
    always_comb begin
        res.line_number  = line_index_reg;
        res.hit_count    = hits_after;
        res.best_count   = top_count_next;
        res.best_line    = top_line_next;
        res.keys_dropped = drop_flag_reg;
    end

    // output register plus skid entry
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;

    assign s_ready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (is_line_end) begin
            if (!out_valid_reg || m_ready) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_reg <= skid_reg;
            end
        end else if (is_line_end) begin
            if (!out_valid_reg || m_ready) begin
                out_reg <= res;
            end else begin
                skid_reg <= res;
            end
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_line_number  = out_reg.line_number;
    assign m_hit_count    = out_reg.hit_count;
    assign m_best_count   = out_reg.best_count;
    assign m_best_line    = out_reg.best_line;
    assign m_keys_dropped = out_reg.keys_dropped;

endmodule

// ----- rtl/core/kwc_checker.sv -----
// port-level checks for the keyword hit counter, bound to the top level
`include "keyword_hit_counter_unit_macros.svh"

module kwc_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [kwc_pkg::LINE_W-1:0]  m_line_number,
    input logic [kwc_pkg::COUNT_W-1:0] m_hit_count,
    input logic [kwc_pkg::COUNT_W-1:0] m_best_count,
    input logic [kwc_pkg::LINE_W-1:0]  m_best_line
);

    // a stalled result stays put
    `KWC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_line_number) && $stable(m_hit_count))

    // the running best is never below the line that was just reported
    `KWC_ASSERT_NOW(a_best_ge_hits, aclk, aresetn, m_valid, m_best_count >= m_hit_count)

    // the best line is never later than the reported line
    `KWC_ASSERT_NOW(a_best_line_order, aclk, aresetn, m_valid, m_best_line <= m_line_number)

    // with no hit yet in the set the best line stays at the first line
    `KWC_ASSERT_NOW(a_best_line_zero, aclk, aresetn, m_valid && (m_best_count == '0), m_best_line == '0)

endmodule

bind keyword_hit_counter_unit kwc_checker u_kwc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_line_number (m_line_number),
    .m_hit_count   (m_hit_count),
    .m_best_count  (m_best_count),
    .m_best_line   (m_best_line)
);

// ----- verif/keyword_hit_counter_unit_checker.sv -----
// line result predictor and scoreboard for the keyword hit counter
`timescale 1ns / 1ps
module keyword_hit_counter_unit_checker #(
    parameter int NUM_KEYS       = kwc_pkg::NUM_KEYS_DEF,
    parameter int MAX_WORD_CHARS = kwc_pkg::MAX_CHARS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    input  logic                         s_ready,
    input  logic [kwc_pkg::OP_W-1:0]     s_operation,
    input  logic [kwc_pkg::SYM_W-1:0]    s_symbol,
    input  logic                         m_valid,
    input  logic                         m_ready,
    input  logic [kwc_pkg::LINE_W-1:0]   m_line_number,
    input  logic [kwc_pkg::COUNT_W-1:0]  m_hit_count,
    input  logic [kwc_pkg::COUNT_W-1:0]  m_best_count,
    input  logic [kwc_pkg::LINE_W-1:0]   m_best_line,
    input  logic                         m_keys_dropped,
    output int                           mismatches,
    output int                           lines_waiting,
    output int                           requests_seen,
    output int                           lines_seen
);

    localparam int WORD_W = kwc_pkg::CODE_W * MAX_WORD_CHARS;

    typedef bit [kwc_pkg::CODE_W-1:0] code_t;

    // predicted keyword table
    bit [WORD_W-1:0]             key_words [NUM_KEYS];
    bit                          key_live  [NUM_KEYS];
    // keyword being loaded
    bit [WORD_W-1:0]             staged_key;
    bit [3:0]                    staged_len;
    bit                          staged_bad;
    // text word being built
    bit [WORD_W-1:0]             text_word;
    bit [3:0]                    text_len;
    bit                          text_overlong;
    // line tally
    bit [kwc_pkg::COUNT_W-1:0]   hits_in_line;
    bit [kwc_pkg::LINE_W-1:0]    line_no;
    bit [kwc_pkg::COUNT_W-1:0]   peak_hits;
    bit [kwc_pkg::LINE_W-1:0]    peak_line;
    bit                          table_overflow;

    kwc_pkg::result_t            expected_lines [$];
    kwc_pkg::result_t            seen;
    kwc_pkg::result_t            want;
    int                          bad_results;
    int                          requests_taken;
    int                          lines_checked;

    function automatic code_t symbol_code(input bit [7:0] c);
        if (c >= "0" && c <= "9") return code_t'(c - 8'd47);
        if (c >= "a" && c <= "z") return code_t'(c - 8'd86);
        return '0;
    endfunction

    function automatic void clear_state();
        for (int k = 0; k < NUM_KEYS; k++) begin
            key_words[k] = '0;
            key_live[k]  = 1'b0;
        end
        staged_key     = '0;
        staged_len     = '0;
        staged_bad     = 1'b0;
        text_word      = '0;
        text_len       = '0;
        text_overlong  = 1'b0;
        hits_in_line   = '0;
        line_no        = '0;
        peak_hits      = '0;
        peak_line      = '0;
        table_overflow = 1'b0;
    endfunction

    // word boundary: parallel compare against every live key
    function automatic void close_word();
        bit hit;
        hit = 1'b0;
        if (text_len != 0 && !text_overlong) begin
            for (int k = 0; k < NUM_KEYS; k++) begin
                if (key_live[k] && key_words[k] == text_word) hit = 1'b1;
            end
        end
        if (hit && hits_in_line != '1) hits_in_line++;
        text_word     = '0;
        text_len      = '0;
        text_overlong = 1'b0;
    endfunction

    function automatic void take_request(input bit [2:0] op, input bit [7:0] sym);
        code_t            code;
        bit [7:0]         folded;
        bit               placed;
        kwc_pkg::result_t line_out;
        placed = 1'b0;
        case (op)
            kwc_pkg::OP_CLEAR: clear_state();
            kwc_pkg::OP_KEY_CHAR: begin
                code = symbol_code(sym);
                if (code == '0 || staged_len >= 4'(MAX_WORD_CHARS)) begin
                    staged_bad = 1'b1;
                end else begin
                    staged_key[kwc_pkg::CODE_W * int'(staged_len) +: kwc_pkg::CODE_W] = code;
                    staged_len++;
                end
            end
            kwc_pkg::OP_KEY_END: begin
                if (!staged_bad && staged_len != 0) begin
                    for (int k = 0; k < NUM_KEYS; k++) begin
                        if (!placed && !key_live[k]) begin
                            key_words[k] = staged_key;
                            key_live[k]  = 1'b1;
                            placed       = 1'b1;
                        end
                    end
                    if (!placed) table_overflow = 1'b1;
                end
                staged_key = '0;
                staged_len = '0;
                staged_bad = 1'b0;
            end
            kwc_pkg::OP_TEXT: begin
                folded = sym;
                if (sym >= "A" && sym <= "Z") folded = sym + 8'd32;
                code = symbol_code(folded);
                if (code == '0) begin
                    close_word();
                end else if (text_len >= 4'(MAX_WORD_CHARS)) begin
                    text_overlong = 1'b1;
                end else begin
                    text_word[kwc_pkg::CODE_W * int'(text_len) +: kwc_pkg::CODE_W] = code;
                    text_len++;
                end
            end
            kwc_pkg::OP_LINE_END: begin
                close_word();
                if (hits_in_line > peak_hits) begin
                    peak_hits = hits_in_line;
                    peak_line = line_no;
                end
                line_out.line_number  = line_no;
                line_out.hit_count    = hits_in_line;
                line_out.best_count   = peak_hits;
                line_out.best_line    = peak_line;
                line_out.keys_dropped = table_overflow;
                expected_lines.insert(expected_lines.size(), line_out);
                hits_in_line = '0;
                if (line_no != '1) line_no++;
            end
            default: ;
        endcase
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_state();
            expected_lines.delete();
        end else begin
            // results first: a line end taken on this edge has its result registered, so it is not seen on this edge
            if (m_valid && m_ready) begin
                seen = {m_line_number, m_hit_count, m_best_count, m_best_line, m_keys_dropped};
                if (expected_lines.size() == 0) begin
                    bad_results++;
                    if (bad_results <= 10)
                        $display("%0t: line result with none expected: line %0d hits %0d",
                                 $time, seen.line_number, seen.hit_count);
                end else begin
                    want = expected_lines.pop_front();
                    lines_checked++;
                    if (seen.line_number  !== want.line_number ||
                        seen.hit_count    !== want.hit_count   ||
                        seen.best_count   !== want.best_count  ||
                        seen.best_line    !== want.best_line   ||
                        seen.keys_dropped !== want.keys_dropped) begin
                        bad_results++;
                        if (bad_results <= 10)
                            $display("%0t: line result mismatch, expected line %0d hits %0d ",
                                     $time, want.line_number, want.hit_count,
                                     "best %0d at %0d dropped %0b; ",
                                     want.best_count, want.best_line, want.keys_dropped,
                                     "got line %0d hits %0d best %0d at %0d dropped %0b",
                                     seen.line_number, seen.hit_count, seen.best_count,
                                     seen.best_line, seen.keys_dropped);
                    end
                end
            end
            if (s_valid && s_ready) begin
                requests_taken++;
                take_request(s_operation, s_symbol);
            end
        end
        mismatches    <= bad_results;
        lines_waiting <= expected_lines.size();
        requests_seen <= requests_taken;
        lines_seen    <= lines_checked;
    end

endmodule

// ----- verif/keyword_hit_counter_unit_tb.sv -----
// testbench top for the keyword hit counter: request stimulus, result stalls, verdict
`timescale 1ns / 1ps
module keyword_hit_counter_unit_tb;
    import kwc_pkg::*;

    localparam int NUM_KEYS        = NUM_KEYS_DEF;
    localparam int MAX_WORD_CHARS  = MAX_CHARS_DEF;
    localparam int RANDOM_REQUESTS = 870;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int DRAIN_CYCLES    = 8;
    // table-full sets load up to four keys past the table size
    localparam int VOCAB_MAX       = NUM_KEYS + 4;
    // words and keys reach two characters past the length limit
    localparam int VOCAB_CHARS     = MAX_WORD_CHARS + 2;

    // receiver behavior, changed after each random span
    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

    logic                 aclk;
    logic                 aresetn     = 1'b0;
    logic                 s_valid     = 1'b0;
    logic                 s_ready;
    logic [OP_W-1:0]      s_operation = '0;
    logic [SYM_W-1:0]     s_symbol    = '0;
    logic                 m_valid;
    logic                 m_ready     = 1'b0;
    logic [LINE_W-1:0]    m_line_number;
    logic [COUNT_W-1:0]   m_hit_count;
    logic [COUNT_W-1:0]   m_best_count;
    logic [LINE_W-1:0]    m_best_line;
    logic                 m_keys_dropped;

    int                   fail_count;
    int                   lines_waiting;
    int                   requests_seen;
    int                   lines_seen;

    // sender burst state and request count that excludes ignored opcodes
    int                   burst_left      = 0;
    int                   useful_requests = 0;

    // keywords of the current set, kept so that text lines can reuse them
    bit [7:0]             vocab_text [VOCAB_MAX][VOCAB_CHARS];
    int                   vocab_len  [VOCAB_MAX];
    int                   vocab_count = 0;

    // receiver stall pattern
    rx_mode_t             rx_mode  = RX_OPEN;
    int                   rx_span  = 0;
    bit [7:0]             rx_phase = '0;

    int                   idle_cycles = 0;

    keyword_hit_counter_unit #(
        .NUM_KEYS       (NUM_KEYS),
        .MAX_WORD_CHARS (MAX_WORD_CHARS)
    ) i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_symbol       (s_symbol),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_line_number  (m_line_number),
        .m_hit_count    (m_hit_count),
        .m_best_count   (m_best_count),
        .m_best_line    (m_best_line),
        .m_keys_dropped (m_keys_dropped)
    );

    // watches both channels, predicts every line result and scores it
    keyword_hit_counter_unit_checker #(
        .NUM_KEYS       (NUM_KEYS),
        .MAX_WORD_CHARS (MAX_WORD_CHARS)
    ) i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_symbol       (s_symbol),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_line_number  (m_line_number),
        .m_hit_count    (m_hit_count),
        .m_best_count   (m_best_count),
        .m_best_line    (m_best_line),
        .m_keys_dropped (m_keys_dropped),
        .mismatches     (fail_count),
        .lines_waiting  (lines_waiting),
        .requests_seen  (requests_seen),
        .lines_seen     (lines_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // receiver: each mode holds for a random span so stalls hit every phase
    always @(posedge aclk) begin
        rx_phase <= rx_phase + 8'd1;
        if (rx_span == 0) begin
            rx_mode <= rx_mode_t'($urandom_range(0, 3));
            rx_span <= $urandom_range(20, 300);
        end else begin
            rx_span <= rx_span - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= ($urandom_range(0, 1) != 0);
            RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            default:   m_ready <= (rx_phase[2:0] < 3'd5);
        endcase
    end

    // watchdog: a stretch with no request and no result taken means a hang
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles, %0d line results outstanding",
                     idle_cycles, lines_waiting);
            $display("Some tests failed");
            $finish;
        end
    end

    // one request; between bursts valid may drop for a random gap
    task automatic push_request(input bit [OP_W-1:0] op, input bit [SYM_W-1:0] sym);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_symbol    <= sym;
        // valid holds with a stable payload until the request is taken
        do @(posedge aclk); while (!s_ready);
        burst_left--;
        if (op <= OP_LINE_END) useful_requests++;
    endtask

    // text folds case, so about half of the letters go out in upper case
    task automatic push_text_char(input bit [7:0] c);
        if (c >= "a" && c <= "z" && $urandom_range(0, 1) != 0) c = c - 8'd32;
        push_request(OP_TEXT, c);
    endtask

    // any byte that is neither a letter nor a digit
    function automatic bit [7:0] pick_separator();
        bit [7:0] c;
        do c = 8'($urandom_range(0, 255));
        while ((c >= "0" && c <= "9") || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z"));
        return c;
    endfunction

    function automatic bit [7:0] pick_alnum();
        int v;
        v = $urandom_range(0, 35);
        return (v < 10) ? 8'("0" + v) : 8'("a" + v - 10);
    endfunction

    // new set: clear, then commit count keywords
    // clean sets hold only well-formed keys so that the table really fills
    task automatic load_keyword_set(input int count, input bit clean);
        int len;
        int roll;
        int src;
        push_request(OP_CLEAR, 8'($urandom_range(0, 255)));
        vocab_count = count;
        for (int k = 0; k < count; k++) begin
            roll = clean ? $urandom_range(20, 99) : $urandom_range(0, 99);
            if (k > 0 && roll < 10) begin
                // duplicate of an earlier key
                src = $urandom_range(0, k - 1);
                vocab_len[k]  = vocab_len[src];
                vocab_text[k] = vocab_text[src];
            end else begin
                if (roll < 13) len = 0;
                else if (roll < 20) len = $urandom_range(MAX_WORD_CHARS + 1, VOCAB_CHARS);
                else if (roll < 75) len = $urandom_range(1, 3);
                else len = $urandom_range(4, MAX_WORD_CHARS);
                vocab_len[k] = len;
                for (int i = 0; i < len; i++) vocab_text[k][i] = pick_alnum();
                // an upper case letter or punctuation spoils the key
                if (!clean && len != 0 && $urandom_range(0, 99) < 8)
                    vocab_text[k][$urandom_range(0, len - 1)] =
                        ($urandom_range(0, 1) != 0) ? 8'("A" + $urandom_range(0, 25))
                                                    : pick_separator();
            end
            for (int i = 0; i < vocab_len[k]; i++) begin
                push_request(OP_KEY_CHAR, vocab_text[k][i]);
                // text traffic in the middle of a key must not disturb it
                if ($urandom_range(0, 99) < 4) push_request(OP_TEXT, 8'($urandom_range(0, 255)));
            end
            push_request(OP_KEY_END, 8'($urandom_range(0, 255)));
        end
    endtask

    // one text line of known keys and random words, then the line end
    task automatic send_line(input int words);
        int len;
        int pick;
        for (int w = 0; w < words; w++) begin
            if (vocab_count > 0 && $urandom_range(0, 99) < 70) begin
                pick = $urandom_range(0, vocab_count - 1);
                for (int i = 0; i < vocab_len[pick]; i++) push_text_char(vocab_text[pick][i]);
            end else begin
                len = $urandom_range(1, VOCAB_CHARS);
                for (int i = 0; i < len; i++) push_text_char(pick_alnum());
            end
            // the last word is often closed by the line end itself
            if (w != words - 1 || $urandom_range(0, 99) < 60)
                repeat ($urandom_range(1, 2)) push_request(OP_TEXT, pick_separator());
        end
        push_request(OP_LINE_END, 8'($urandom_range(0, 255)));
    endtask

    initial begin
        int mark;
        int roll;

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // ---- directed part ----
        push_request(OP_CLEAR, 8'hFF);
        // key "z9"
        push_request(OP_KEY_CHAR, "z");
        push_request(OP_KEY_CHAR, "9");
        push_request(OP_KEY_END, 8'h00);
        // empty key commit takes no slot
        push_request(OP_KEY_END, 8'hFF);
        // upper case key character spoils the key
        push_request(OP_KEY_CHAR, "Q");
        push_request(OP_KEY_END, 8'h00);
        // duplicate key is stored again
        push_request(OP_KEY_CHAR, "z");
        push_request(OP_KEY_CHAR, "9");
        push_request(OP_KEY_END, 8'h00);
        // "Z" alone is no hit; byte 255 ends the word
        push_request(OP_TEXT, "Z");
        push_request(OP_TEXT, 8'hFF);
        push_request(OP_TEXT, "z");
        push_request(OP_TEXT, "9");
        // key loading in the middle of a text word
        push_request(OP_KEY_CHAR, "0");
        push_request(OP_TEXT, 8'h00);
        // undefined opcodes are ignored
        push_request(3'd5, 8'hFF);
        push_request(3'd7, 8'h00);
        // line end closes the open word "Z9"
        push_request(OP_TEXT, "Z");
        push_request(OP_TEXT, "9");
        push_request(OP_LINE_END, 8'hFF);
        // empty line ties nothing and leaves the best line alone
        push_request(OP_LINE_END, 8'h00);
        push_request(OP_KEY_END, 8'h00);
        push_request(3'd6, 8'h55);

        // ---- hit count saturation: one line with 300 hits of "a" ----
        push_request(OP_CLEAR, 8'h00);
        push_request(OP_KEY_CHAR, "a");
        push_request(OP_KEY_END, 8'h00);
        for (int i = 0; i < 300; i++) begin
            push_text_char("a");
            push_request(OP_TEXT, pick_separator());
        end
        push_request(OP_LINE_END, 8'h00);

        // ---- random part: mostly key sets and text lines, some raw noise ----
        mark = useful_requests;
        load_keyword_set($urandom_range(1, 6), 1'b0);
        while (useful_requests - mark < RANDOM_REQUESTS) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) begin
                load_keyword_set($urandom_range(1, 6), 1'b0);
            end else if (roll < 11) begin
                // more good keys than the table holds
                load_keyword_set($urandom_range(NUM_KEYS + 1, VOCAB_MAX), 1'b1);
            end else if (roll < 90) begin
                send_line($urandom_range(0, 8));
            end else begin
                repeat ($urandom_range(1, 6))
                    push_request(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
            end
        end

        // ---- drain ----
        s_valid <= 1'b0;
        @(posedge aclk);
        while (lines_waiting != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run: %0d requests taken, %0d line results checked, %0d mismatches",
                 requests_seen, lines_seen, fail_count);
        $display("run: covered key set limits, bad and duplicate keys, hit saturation, text noise");
        if (fail_count == 0 && lines_waiting == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
